### design/circle_outline_canvas_plotter_assert.svh
// assertion macros used by the plotter datapath
`ifndef CIRCLE_OUTLINE_CANVAS_PLOTTER_ASSERT_SVH
`define CIRCLE_OUTLINE_CANVAS_PLOTTER_ASSERT_SVH
`ifndef SYNTHESIS
`define COCP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define COCP_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define COCP_ASSERT(lbl, clk, rst_n, prop, msg)
`define COCP_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### design/cocp_pkg.sv
`timescale 1ns / 1ps
package cocp_pkg;

    localparam int CMD_W   = 2;
    localparam int CRD_W   = 16;
    localparam int VAL_W   = 8;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 1;
    localparam int DIM_W   = 13;
    localparam int PT_W    = 18;
    localparam int RSQ_W   = 32;
    localparam int LIM_W   = 23;
    localparam int REM_W   = 18;
    localparam int SQ_CNT_W = 4;
    localparam int IDX_W   = 3;

    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 9'd256;

    // loop bound 100*dy < 71*r
    localparam int K_NUM = 71;
    localparam int K_DEN = 100;

    typedef enum logic [1:0] {
        PT_AXIS,
        PT_CIRC,
        PT_READ
    } pt_sel_t;

    typedef struct packed {
        logic    accept;
        logic    draw_init;
        logic    pt_load;
        pt_sel_t pt_sel;
        logic    sqrt_init;
        logic    sqrt_step;
        logic    rd_capture;
        logic    clr_step;
    } cocp_cmd_t;

    typedef struct packed {
        logic axis_last;
        logic circ_last;
        logic loop_go;
        logic sqrt_last;
        logic clr_last;
        logic out_free;
    } cocp_stat_t;

endpackage

### design/cocp_ram.sv
`timescale 1ns / 1ps
module cocp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/cocp_datapath.sv
`timescale 1ns / 1ps
`include "circle_outline_canvas_plotter_assert.svh"
module cocp_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cocp_pkg::cocp_cmd_t            cmd,
    output cocp_pkg::cocp_stat_t           stat,
    input  logic [cocp_pkg::CRD_W-1:0]     pos_x,
    input  logic [cocp_pkg::CRD_W-1:0]     pos_y,
    input  logic [cocp_pkg::CRD_W-1:0]     radius,
    input  logic [cocp_pkg::VAL_W-1:0]     intensity,
    input  logic                           cfg_wr_en,
    input  logic [cocp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cocp_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cocp_pkg::VAL_W-1:0]     pixel_value,
    output logic                           read_in_range
);
    import cocp_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [CFG_W-1:0]  cfg_w_reg, cfg_h_reg;
    logic [DIM_W-1:0]  eff_w, eff_h;

    logic [CRD_W-1:0]  x_reg, y_reg, r_reg, dy_reg;
    logic [VAL_W-1:0]  v_reg;
    logic [RSQ_W-1:0]  n_reg;
    logic [LIM_W-1:0]  lim_reg, acc_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [SQ_CNT_W-1:0] sq_cnt_reg;
    logic [REM_W-1:0]    sq_rem_reg;
    logic [CRD_W-1:0]    sq_root_reg;
    logic [1:0]          sq_pair;
    logic [REM_W+1:0]    sq_shift, sq_trial;

    logic [CRD_W-1:0]  off_x, off_y;
    logic              neg_x, neg_y;
    logic [PT_W-1:0]   px, py;
    logic              px_ok, py_ok;

    logic              pt_vld_reg, pt_rd_reg, pt_ok_reg;
    logic [XW-1:0]     pt_x_reg;
    logic [YW-1:0]     pt_y_reg;
    logic [AW-1:0]     pt_addr;

    logic [AW-1:0]     clr_addr_reg;
    logic              out_valid_reg;
    logic [VAL_W-1:0]  pixel_reg;
    logic              in_range_reg;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr;
    logic [VAL_W-1:0]  mem_wdata, mem_rdata;

    // sizes above the maximum act as the maximum
    assign eff_w = ({4'b0, cfg_w_reg} > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                           : {4'b0, cfg_w_reg};
    assign eff_h = ({4'b0, cfg_h_reg} > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                            : {4'b0, cfg_h_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg <= CFG_DIM_RESET;
            cfg_h_reg <= CFG_DIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CANVAS_WIDTH:  cfg_w_reg <= cfg_wdata;
                CFG_CANVAS_HEIGHT: cfg_h_reg <= cfg_wdata;
                default:           cfg_w_reg <= cfg_w_reg;
            endcase
        end
    end

    // point offsets for the current plot slot
    always_comb
    begin
        off_x = '0;
        off_y = '0;
        neg_x = 1'b0;
        neg_y = 1'b0;
        unique case (cmd.pt_sel)
            PT_AXIS:
            begin
                if (idx_reg[1])
                begin
                    off_y = r_reg;
                    neg_y = idx_reg[0];
                end
                else
                begin
                    off_x = r_reg;
                    neg_x = idx_reg[0];
                end
            end
            PT_CIRC:
            begin
                off_x = idx_reg[2] ? dy_reg : sq_root_reg;
                off_y = idx_reg[2] ? sq_root_reg : dy_reg;
                neg_x = idx_reg[0];
                neg_y = !idx_reg[1];
            end
            PT_READ:
            begin
                off_x = '0;
                off_y = '0;
            end
            default:
            begin
                off_x = '0;
                off_y = '0;
            end
        endcase
    end

    assign px = neg_x ? ({2'b0, x_reg} - {2'b0, off_x}) : ({2'b0, x_reg} + {2'b0, off_x});
    assign py = neg_y ? ({2'b0, y_reg} - {2'b0, off_y}) : ({2'b0, y_reg} + {2'b0, off_y});
    assign px_ok = !px[PT_W-1] && (px[PT_W-2:0] < (PT_W-1)'(eff_w));
    assign py_ok = !py[PT_W-1] && (py[PT_W-2:0] < (PT_W-1)'(eff_h));

    // one pair of radicand bits per step, msb pair first
    assign sq_pair  = n_reg[{~sq_cnt_reg, 1'b0} +: 2];
    assign sq_shift = {sq_rem_reg, sq_pair};
    assign sq_trial = (REM_W+2)'({sq_root_reg, 2'b01});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            sq_cnt_reg  <= '0;
            pt_vld_reg  <= 1'b0;
            clr_addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.draw_init)
            begin
                idx_reg <= '0;
            end
            else if (cmd.pt_load && cmd.pt_sel != PT_READ)
            begin
                idx_reg <= (cmd.pt_sel == PT_AXIS && stat.axis_last) ? '0 : idx_reg + 1'b1;
            end

            if (cmd.sqrt_init)
            begin
                sq_cnt_reg <= '0;
            end
            else if (cmd.sqrt_step)
            begin
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            end

            pt_vld_reg <= cmd.pt_load;

            if (cmd.clr_step)
            begin
                clr_addr_reg <= stat.clr_last ? '0 : clr_addr_reg + 1'b1;
            end

            if (cmd.rd_capture)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg <= pos_x;
            y_reg <= pos_y;
            r_reg <= radius;
            v_reg <= intensity;
        end

        if (cmd.draw_init)
        begin
            n_reg   <= RSQ_W'(r_reg) * RSQ_W'(r_reg);
            lim_reg <= LIM_W'(r_reg) * LIM_W'(K_NUM);
            acc_reg <= LIM_W'(K_DEN);
            dy_reg  <= CRD_W'(1);
        end
        else if (cmd.sqrt_init)
        begin
            // r*r - dy*dy kept by subtracting 2*dy - 1 per step
            n_reg <= n_reg - RSQ_W'({dy_reg, 1'b0}) + RSQ_W'(1);
        end
        else if (cmd.pt_load && cmd.pt_sel == PT_CIRC && stat.circ_last)
        begin
            dy_reg  <= dy_reg + 1'b1;
            acc_reg <= acc_reg + LIM_W'(K_DEN);
        end

        if (cmd.sqrt_init)
        begin
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_shift >= sq_trial)
            begin
                sq_rem_reg  <= REM_W'(sq_shift - sq_trial);
                sq_root_reg <= {sq_root_reg[CRD_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= REM_W'(sq_shift);
                sq_root_reg <= {sq_root_reg[CRD_W-2:0], 1'b0};
            end
        end

        if (cmd.pt_load)
        begin
            pt_rd_reg <= (cmd.pt_sel == PT_READ);
            pt_ok_reg <= px_ok && py_ok;
            pt_x_reg  <= px[XW-1:0];
            pt_y_reg  <= py[YW-1:0];
        end

        if (cmd.rd_capture)
        begin
            pixel_reg    <= pt_ok_reg ? mem_rdata : '0;
            in_range_reg <= pt_ok_reg;
        end
    end

    assign pt_addr = AW'(pt_y_reg) * AW'(MAX_WIDTH) + AW'(pt_x_reg);

    assign mem_we    = cmd.clr_step || (pt_vld_reg && !pt_rd_reg && pt_ok_reg);
    assign mem_re    = pt_vld_reg && pt_rd_reg && pt_ok_reg;
    assign mem_waddr = cmd.clr_step ? clr_addr_reg : pt_addr;
    assign mem_wdata = cmd.clr_step ? '0 : v_reg;

    cocp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_canvas (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (pt_addr),
        .rdata (mem_rdata)
    );

    assign stat.axis_last = (idx_reg == IDX_W'(3));
    assign stat.circ_last = (idx_reg == IDX_W'(7));
    assign stat.loop_go   = (acc_reg < lim_reg);
    assign stat.sqrt_last = (sq_cnt_reg == '1);
    assign stat.clr_last  = (clr_addr_reg == AW'(DEPTH - 1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign pixel_value   = pixel_reg;
    assign read_in_range = in_range_reg;

    `COCP_NEVER(a_rw_excl, clk, rst_n, mem_we && mem_re, "canvas written and read together")
    `COCP_ASSERT(a_cap_free, clk, rst_n, cmd.rd_capture |-> (!out_valid_reg || out_ready), "read result overwrites a pending beat")
    `COCP_ASSERT(a_clr_walk, clk, rst_n, (cmd.clr_step && !stat.clr_last) |=> (clr_addr_reg == AW'($past(clr_addr_reg) + 1'b1)), "clear sweep skipped an entry")
    `COCP_NEVER(a_rd_hold, clk, rst_n, pt_vld_reg && pt_rd_reg && cmd.pt_load, "pending read overtaken by a new point")

endmodule

### design/cocp_ctrl.sv
`timescale 1ns / 1ps
module cocp_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [cocp_pkg::CMD_W-1:0] in_cmd,
    input  cocp_pkg::cocp_stat_t       stat,
    output cocp_pkg::cocp_cmd_t        cmd
);
    import cocp_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DRAW_INIT,
        S_AXIS,
        S_COND,
        S_SQRT,
        S_PLOT,
        S_RD_PT,
        S_RD_MEM,
        S_RD_CAP
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.pt_sel = PT_READ;
        in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    priority if (in_cmd == CMD_DRAW)
                    begin
                        state_next = S_DRAW_INIT;
                    end
                    else if (in_cmd == CMD_READ)
                    begin
                        state_next = S_RD_PT;
                    end
                    else if (in_cmd == CMD_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DRAW_INIT:
            begin
                cmd.draw_init = 1'b1;
                state_next = S_AXIS;
            end
            S_AXIS:
            begin
                cmd.pt_load = 1'b1;
                cmd.pt_sel = PT_AXIS;
                if (stat.axis_last)
                begin
                    state_next = S_COND;
                end
            end
            S_COND:
            begin
                if (stat.loop_go)
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next = S_SQRT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                begin
                    state_next = S_PLOT;
                end
            end
            S_PLOT:
            begin
                cmd.pt_load = 1'b1;
                cmd.pt_sel = PT_CIRC;
                if (stat.circ_last)
                begin
                    state_next = S_COND;
                end
            end
            S_RD_PT:
            begin
                cmd.pt_load = 1'b1;
                cmd.pt_sel = PT_READ;
                state_next = S_RD_MEM;
            end
            S_RD_MEM:
            begin
                state_next = S_RD_CAP;
            end
            S_RD_CAP:
            begin
                if (stat.out_free)
                begin
                    cmd.rd_capture = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/circle_outline_canvas_plotter.sv
// read: the point is registered, the canvas is read, then the result is captured
// once the result port is free; clear: a sweep over all MAX_WIDTH*MAX_HEIGHT entries
// draw: four axis points, then per dy step (dy below about 0.71*radius) a setup, the
// bit-pair square root and up to 8 canvas writes; one item at a time, as a new item
// is taken only while idle; after reset the canvas is zeroed by a sweep of all entries,
// during which no item is taken; sizes reset to 256 x 256
`timescale 1ns / 1ps
module circle_outline_canvas_plotter #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // cmd[1:0], pos_x[17:2], pos_y[33:18], radius[49:34], intensity[57:50], zero above
    input  logic [63:0]                    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixel_value[7:0], read_in_range[8], zero above
    output logic [15:0]                    m_axis_tdata,
    input  logic                           cfg_wr_en,
    input  logic [cocp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cocp_pkg::CFG_W-1:0]     cfg_wdata
);
    import cocp_pkg::*;

    cocp_cmd_t        cmd;
    cocp_stat_t       stat;
    logic [VAL_W-1:0] pixel_value;
    logic             read_in_range;

    cocp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tdata[1:0]),
        .stat     (stat),
        .cmd      (cmd)
    );

    cocp_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .pos_x         (s_axis_tdata[17:2]),
        .pos_y         (s_axis_tdata[33:18]),
        .radius        (s_axis_tdata[49:34]),
        .intensity     (s_axis_tdata[57:50]),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .pixel_value   (pixel_value),
        .read_in_range (read_in_range)
    );

    assign m_axis_tdata = {7'b0, read_in_range, pixel_value};

endmodule

### verif/circle_outline_canvas_plotter_tb.sv
`timescale 1ns / 1ps
module circle_outline_canvas_plotter_tb;
    import cocp_pkg::*;

    localparam int MAX_W = 256;
    localparam int MAX_H = 256;
    localparam int LONG_HOLD = 400;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0]  intensity;
        logic [15:0] radius;
        logic [15:0] pos_y;
        logic [15:0] pos_x;
        logic [1:0]  cmd;
    } plot_cmd_t;

    typedef struct packed {
        logic [7:0] pix;
        logic       inr;
    } pix_result_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SET_WIDTH,
        ROW_SET_HEIGHT
    } row_kind_t;

    // size rows carry the register value in rad
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  cmd;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] rad;
        logic [7:0]  val;
        logic        typed;
        logic [7:0]  pix;
        logic        inr;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    circle_outline_canvas_plotter #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // shadow canvas and sizes
    logic [7:0]       canvas_ref [0:MAX_W*MAX_H-1];
    logic [CFG_W-1:0] width_ref;
    logic [CFG_W-1:0] height_ref;

    pix_result_t pix_expect_q [$];
    int          err_cnt = 0;
    bit          idle_on = 1'b1;
    bit          long_hold_pending = 1'b0;

    int last_cx = 0;
    int last_cy = 0;
    int last_r  = -1;

    stim_row_t dir_rows [0:33] = '{
        '{ROW_ITEM, CMD_READ,   16'd0,     16'd0,     16'd0,     8'h00, 1'b1, 8'h00, 1'b1},
        '{ROW_ITEM, CMD_READ,   16'd65535, 16'd65535, 16'd0,     8'h00, 1'b1, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_READ,   16'd255,   16'd255,   16'd0,     8'h00, 1'b1, 8'h00, 1'b1},
        '{ROW_ITEM, CMD_DRAW,   16'd128,   16'd128,   16'd10,    8'hFF, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_READ,   16'd138,   16'd128,   16'd0,     8'h00, 1'b1, 8'hFF, 1'b1},
        '{ROW_ITEM, CMD_READ,   16'd128,   16'd118,   16'd0,     8'h00, 1'b1, 8'hFF, 1'b1},
        '{ROW_ITEM, CMD_READ,   16'd135,   16'd121,   16'd0,     8'h00, 1'b0, 8'h00, 1'b0},
        // zero radius: center only
        '{ROW_ITEM, CMD_DRAW,   16'd50,    16'd60,    16'd0,     8'hAA, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_READ,   16'd50,    16'd60,    16'd0,     8'h00, 1'b1, 8'hAA, 1'b1},
        // corner circle, negative points dropped
        '{ROW_ITEM, CMD_DRAW,   16'd0,     16'd0,     16'd5,     8'h55, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_READ,   16'd5,     16'd0,     16'd0,     8'h00, 1'b1, 8'h55, 1'b1},
        '{ROW_ITEM, CMD_READ,   16'd4,     16'd3,     16'd0,     8'h00, 1'b0, 8'h00, 1'b0},
        // largest radius, left axis point lands on the origin
        '{ROW_ITEM, CMD_DRAW,   16'd65535, 16'd0,     16'd65535, 8'h3C, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_READ,   16'd0,     16'd0,     16'd0,     8'h00, 1'b1, 8'h3C, 1'b1},
        '{ROW_ITEM, CMD_READ,   16'd1,     16'd200,   16'd0,     8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_UNUSED, 16'd65535, 16'd65535, 16'd65535, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_CLEAR,  16'd0,     16'd0,     16'd0,     8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_READ,   16'd138,   16'd128,   16'd0,     8'h00, 1'b1, 8'h00, 1'b1},
        // zero width hides everything
        '{ROW_SET_WIDTH,  CMD_UNUSED, 16'd0, 16'd0, 16'd0,   8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_DRAW,   16'd10,    16'd10,    16'd3,     8'h11, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_READ,   16'd0,     16'd0,     16'd0,     8'h00, 1'b1, 8'h00, 1'b0},
        // sizes above the maximum clamp
        '{ROW_SET_WIDTH,  CMD_UNUSED, 16'd0, 16'd0, 16'd511, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_SET_HEIGHT, CMD_UNUSED, 16'd0, 16'd0, 16'd300, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_READ,   16'd13,    16'd10,    16'd0,     8'h00, 1'b1, 8'h00, 1'b1},
        '{ROW_SET_WIDTH,  CMD_UNUSED, 16'd0, 16'd0, 16'd1,   8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_SET_HEIGHT, CMD_UNUSED, 16'd0, 16'd0, 16'd1,   8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_DRAW,   16'd0,     16'd0,     16'd0,     8'h77, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_READ,   16'd0,     16'd0,     16'd0,     8'h00, 1'b1, 8'h77, 1'b1},
        '{ROW_ITEM, CMD_READ,   16'd1,     16'd0,     16'd0,     8'h00, 1'b1, 8'h00, 1'b0},
        // growing back keeps stored pixels
        '{ROW_SET_WIDTH,  CMD_UNUSED, 16'd0, 16'd0, 16'd256, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_SET_HEIGHT, CMD_UNUSED, 16'd0, 16'd0, 16'd256, 8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_READ,   16'd0,     16'd0,     16'd0,     8'h00, 1'b1, 8'h77, 1'b1},
        '{ROW_ITEM, CMD_DRAW,   16'd0,     16'd0,     16'd0,     8'h00, 1'b0, 8'h00, 1'b0},
        '{ROW_ITEM, CMD_READ,   16'd0,     16'd0,     16'd0,     8'h00, 1'b1, 8'h00, 1'b1}
    };

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint vis_w();
        return (width_ref > MAX_W) ? MAX_W : width_ref;
    endfunction

    function automatic longint vis_h();
        return (height_ref > MAX_H) ? MAX_H : height_ref;
    endfunction

    function automatic longint floor_sqrt(longint n);
        longint root;
        longint cand;
        root = 0;
        for (int b = 16; b >= 0; b--) begin
            cand = root | (longint'(1) << b);
            if (cand * cand <= n)
                root = cand;
        end
        return root;
    endfunction

    function automatic void put_px(longint x, longint y, logic [7:0] v);
        if (x < 0 || y < 0 || x >= vis_w() || y >= vis_h())
            return;
        canvas_ref[y * MAX_W + x] = v;
    endfunction

    function automatic void trace_circle(longint cx, longint cy, longint r, logic [7:0] v);
        longint dx;
        put_px(cx + r, cy, v);
        put_px(cx - r, cy, v);
        put_px(cx, cy + r, v);
        put_px(cx, cy - r, v);
        for (longint dy = 1; 100 * dy < 71 * r; dy++) begin
            dx = floor_sqrt(r * r - dy * dy);
            put_px(cx + dx, cy - dy, v);
            put_px(cx - dx, cy - dy, v);
            put_px(cx + dx, cy + dy, v);
            put_px(cx - dx, cy + dy, v);
            put_px(cx + dy, cy - dx, v);
            put_px(cx - dy, cy - dx, v);
            put_px(cx + dy, cy + dx, v);
            put_px(cx - dy, cy + dx, v);
        end
    endfunction

    // updates the shadow canvas; returns 1 when the command yields a beat
    function automatic bit canvas_apply(plot_cmd_t c, output pix_result_t res);
        res = '0;
        case (c.cmd)
            CMD_DRAW:
                trace_circle(c.pos_x, c.pos_y, c.radius, c.intensity);
            CMD_READ:
            begin
                if (c.pos_x < vis_w() && c.pos_y < vis_h()) begin
                    res.pix = canvas_ref[int'(c.pos_y) * MAX_W + int'(c.pos_x)];
                    res.inr = 1'b1;
                end
                return 1'b1;
            end
            CMD_CLEAR:
                foreach (canvas_ref[i]) canvas_ref[i] = 8'h00;
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void flag_error(string what, int exp_v, int act_v);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, exp_v, act_v);
    endfunction

    task automatic send_cmd(plot_cmd_t c, bit typed, logic [7:0] tpix, logic tinr);
        pix_result_t res;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, c};
        do @(posedge clk); while (!s_axis_tready);
        if (canvas_apply(c, res)) begin
            if (typed) begin
                res.pix = tpix;
                res.inr = tinr;
            end
            pix_expect_q.push_back(res);
        end
    endtask

    // every phase ends on a read, so an empty queue means the block is idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pix_expect_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == CFG_CANVAS_WIDTH)
            width_ref = value;
        else
            height_ref = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_size();
        int sel;
        sel = $urandom_range(0, 39);
        if (sel == 0)
            return '0;
        else if (sel < 7)
            return CFG_W'($urandom_range(257, 511));
        else if (sel < 13)
            return CFG_W'($urandom_range(1, 16));
        else if (sel < 24)
            return CFG_W'(256);
        return CFG_W'($urandom_range(17, 255));
    endfunction

    task automatic random_phase(int n_items, int lead_reads);
        plot_cmd_t c;
        int        done;
        int        sel;
        int        dx;
        int        dy;
        int        t;
        int        x;
        int        y;
        done = 0;
        while (done < n_items) begin
            c = '0;
            c.intensity = 8'($urandom());
            sel = $urandom_range(0, 199);
            if (done < lead_reads || done == n_items - 1 || sel >= 90) begin
                c.cmd = CMD_READ;
                sel = $urandom_range(0, 9);
                if (sel < 5 && last_r >= 0) begin
                    // land on or near the last outline
                    dy = $urandom_range(0, last_r * 71 / 100);
                    dx = int'(floor_sqrt(longint'(last_r) * last_r - longint'(dy) * dy));
                    if ($urandom_range(0, 1)) begin
                        t = dx;
                        dx = dy;
                        dy = t;
                    end
                    x = $urandom_range(0, 1) ? last_cx + dx : last_cx - dx;
                    y = $urandom_range(0, 1) ? last_cy + dy : last_cy - dy;
                end else if (sel < 9) begin
                    x = $urandom_range(0, int'(vis_w()) + 3);
                    y = $urandom_range(0, int'(vis_h()) + 3);
                end else begin
                    x = $urandom();
                    y = $urandom();
                end
                c.pos_x = 16'(x);
                c.pos_y = 16'(y);
                c.radius = 16'($urandom());
            end else if (sel < 2) begin
                c.cmd = CMD_CLEAR;
            end else if (sel < 8) begin
                c.cmd    = CMD_UNUSED;
                c.pos_x  = 16'($urandom());
                c.pos_y  = 16'($urandom());
                c.radius = 16'($urandom());
            end else begin
                c.cmd = CMD_DRAW;
                if ($urandom_range(0, 19) != 0) begin
                    c.pos_x = 16'($urandom_range(0, int'(vis_w()) + 20));
                    c.pos_y = 16'($urandom_range(0, int'(vis_h()) + 20));
                end else begin
                    c.pos_x = 16'($urandom());
                    c.pos_y = 16'($urandom());
                end
                sel = $urandom_range(0, 99);
                if (sel < 90)
                    c.radius = 16'($urandom_range(0, 40));
                else if (sel < 99)
                    c.radius = 16'($urandom_range(41, 255));
                else
                    c.radius = 16'($urandom_range(256, 1000));
                last_cx = c.pos_x;
                last_cy = c.pos_y;
                last_r  = c.radius;
            end
            send_cmd(c, 1'b0, 8'h00, 1'b0);
            if (c.cmd != CMD_UNUSED)
                done++;
        end
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            @(posedge clk);
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        pix_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pix_expect_q.size() == 0) begin
                flag_error("unexpected result beat", 0, m_axis_tdata);
            end else begin
                want = pix_expect_q.pop_front();
                if (m_axis_tdata[7:0] !== want.pix)
                    flag_error("pixel_value", want.pix, m_axis_tdata[7:0]);
                if (m_axis_tdata[8] !== want.inr)
                    flag_error("read_in_range", want.inr, m_axis_tdata[8]);
            end
        end
    end

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= CFG_CANVAS_WIDTH;
        cfg_wdata     <= '0;
        rst_n         <= 1'b0;
        foreach (canvas_ref[i]) canvas_ref[i] = 8'h00;
        width_ref  = CFG_DIM_RESET;
        height_ref = CFG_DIM_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_ITEM:
                    send_cmd('{dir_rows[i].val, dir_rows[i].rad, dir_rows[i].py,
                               dir_rows[i].px, dir_rows[i].cmd},
                             dir_rows[i].typed, dir_rows[i].pix, dir_rows[i].inr);
                ROW_SET_WIDTH:
                begin
                    settle();
                    set_size(CFG_CANVAS_WIDTH, dir_rows[i].rad[CFG_W-1:0]);
                end
                default:
                begin
                    settle();
                    set_size(CFG_CANVAS_HEIGHT, dir_rows[i].rad[CFG_W-1:0]);
                end
            endcase
        end
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            idle_on = (ph != 4) && (ph != 7);
            set_size(CFG_CANVAS_WIDTH, pick_size());
            set_size(CFG_CANVAS_HEIGHT, pick_size());
            // reads pile up behind a stalled result port
            if (ph == 2)
                long_hold_pending = 1'b1;
            random_phase(70, (ph == 2) ? 24 : 0);
            settle();
        end
        repeat (20) @(posedge clk);

        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
